/* hdl/gdd_pkg.sv */
// Shared types, constants and unit decoding for the Gregorian date decrement block.
// No dependencies; used by gdd_step and gregorian_date_decrement.
package gdd_pkg;

    // Count bits honoured from the 16-bit count field (1..16).
    localparam int COUNT_BITS = 16;
    localparam int CNT_W      = (COUNT_BITS < 16) ? COUNT_BITS : 16;
    // Step counter: a week count is seven day steps.
    localparam int LEFT_W     = CNT_W + 3;
    localparam int SCALE_W    = 10;

    // Unit selector codes.
    localparam logic [2:0] FN_DAY        = 3'd0;
    localparam logic [2:0] FN_WEEK       = 3'd1;
    localparam logic [2:0] FN_MONTH      = 3'd2;
    localparam logic [2:0] FN_YEAR       = 3'd3;
    localparam logic [2:0] FN_DECADE     = 3'd4;
    localparam logic [2:0] FN_CENTURY    = 3'd5;
    localparam logic [2:0] FN_MILLENNIUM = 3'd6;

    // Operations of the shared step unit.
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_DAY   = 2'd1;
    localparam logic [1:0] OP_MONTH = 2'd2;
    localparam logic [1:0] OP_YEAR  = 2'd3;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [15:0] year;
    } t_date;

    typedef struct packed {
        logic [1:0]         op;
        logic [SCALE_W-1:0] scale;
    } t_step_req;

    function automatic logic [1:0] op_of(input logic [2:0] func);
        logic [1:0] op;
        case (func) inside
            FN_DAY, FN_WEEK: op = OP_DAY;
            FN_MONTH:        op = OP_MONTH;
            FN_YEAR, FN_DECADE, FN_CENTURY, FN_MILLENNIUM: op = OP_YEAR;
            default:         op = OP_NONE;
        endcase
        return op;
    endfunction

    function automatic logic [SCALE_W-1:0] scale_of(input logic [2:0] func);
        logic [SCALE_W-1:0] s;
        case (func)
            FN_YEAR:       s = SCALE_W'(1);
            FN_DECADE:     s = SCALE_W'(10);
            FN_CENTURY:    s = SCALE_W'(100);
            FN_MILLENNIUM: s = SCALE_W'(1000);
            default:       s = '0;
        endcase
        return s;
    endfunction

endpackage

/* hdl/gdd_step.sv */
// Shared step unit: moves a date back by one day, one month, or a scaled count of years.
// Depends on gdd_pkg for the date and request types.
module gdd_step (
    input  gdd_pkg::t_step_req           i_req,
    input  gdd_pkg::t_date               i_date,
    input  logic [gdd_pkg::CNT_W-1:0]    i_count,
    output gdd_pkg::t_date               o_date
);

    // Multiplicative inverse of 25 modulo 2^16 and the divisibility bound.
    localparam logic [15:0] INV25   = 16'd23593;
    localparam logic [15:0] DIV25_MAX = 16'd2621;

    logic [15:0] year_abs;
    logic [15:0] inv_prod;
    logic        div4;
    logic        div16;
    logic        div25;
    logic        leap;
    logic [3:0]  month_prev;
    logic [4:0]  prev_len;
    logic [15:0] count_ext;
    logic [15:0] year_prod;

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic lp);
        logic [4:0] len;
        case (m) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = lp ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // Gregorian rule on the signed year: divisible by 4 but not 100, or by 400.
    assign year_abs = i_date.year[15] ? (16'd0 - i_date.year) : i_date.year;
    assign inv_prod = year_abs * INV25;
    assign div4     = (i_date.year[1:0] == 2'b00);
    assign div16    = (i_date.year[3:0] == 4'b0000);
    assign div25    = (inv_prod <= DIV25_MAX);
    assign leap     = (div4 && !div25) || (div16 && div25);

    assign month_prev = i_date.month - 4'd1;
    assign prev_len   = month_days(month_prev, leap);

    // the year wraps modulo 2^16, so the low half of the product is enough
    assign count_ext = 16'(i_count);
    assign year_prod = count_ext * 16'(i_req.scale);

    always_comb begin
        o_date = i_date;
        unique case (i_req.op)
            gdd_pkg::OP_DAY: begin
                if (i_date.day <= 5'd1) begin
                    if (i_date.month <= 4'd1) begin
                        o_date.day   = 5'd31;
                        o_date.month = 4'd12;
                        o_date.year  = i_date.year - 16'd1;
                    end else begin
                        o_date.month = month_prev;
                        o_date.day   = prev_len;
                    end
                end else begin
                    o_date.day = i_date.day - 5'd1;
                end
            end
            gdd_pkg::OP_MONTH: begin
                if (i_date.month <= 4'd1) begin
                    // December is always 31 days long: no clamp needed
                    o_date.month = 4'd12;
                    o_date.year  = i_date.year - 16'd1;
                end else begin
                    o_date.month = month_prev;
                    if (i_date.day > prev_len) begin
                        o_date.day = prev_len;
                    end
                end
            end
            gdd_pkg::OP_YEAR: begin
                o_date.year = i_date.year - year_prod;
            end
            default: begin
                o_date = i_date;
            end
        endcase
    end

endmodule

/* hdl/gregorian_date_decrement.sv */
// Top level of the Gregorian date decrement block: sequencer, step counter, output register.
// Depends on gdd_pkg and gdd_step.
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+--------------------------------------------------
//  input   | i_valid | o_ready | i_day_in, i_month_in, i_year_in, i_func, i_count
//  output  | o_valid | i_ready | o_day_out, o_month_out, o_year_out
//
// The single step unit moves the date one day or one month a cycle.
// o_ready is high only while the sequencer is idle; a finished result sits in the output
// register, so a new beat may be taken while it waits. A result that finds the output
// register still full holds in the sequencer until it is taken.
// Reset (synchronous, active low) clears the sequencer and the output valid.
module gregorian_date_decrement (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [4:0]           i_day_in,
    input  logic [3:0]           i_month_in,
    input  logic signed [15:0]   i_year_in,
    input  logic [2:0]           i_func,
    input  logic [15:0]          i_count,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [4:0]           o_day_out,
    output logic [3:0]           o_month_out,
    output logic signed [15:0]   o_year_out
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic                         r_state;
    logic                         n_state;
    logic [gdd_pkg::LEFT_W-1:0]   r_left;
    logic [gdd_pkg::LEFT_W-1:0]   n_left;
    logic [gdd_pkg::CNT_W-1:0]    r_count;
    gdd_pkg::t_step_req           r_req;
    gdd_pkg::t_date               r_date;
    gdd_pkg::t_date               n_date;
    gdd_pkg::t_date               step_date;
    logic                         r_out_valid;
    gdd_pkg::t_date               r_out;

    logic                         accept;
    logic                         finish;
    logic [gdd_pkg::CNT_W-1:0]    cnt_in;
    logic [gdd_pkg::LEFT_W-1:0]   cnt_ext;
    logic [4:0]                   day_norm;
    logic [3:0]                   month_norm;

    gdd_step u_step (
        .i_req   (r_req),
        .i_date  (r_date),
        .i_count (r_count),
        .o_date  (step_date)
    );

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign finish  = (r_state == S_RUN) && (r_left == '0) && (!r_out_valid || i_ready);

    assign cnt_in     = i_count[gdd_pkg::CNT_W-1:0];
    assign cnt_ext    = gdd_pkg::LEFT_W'(cnt_in);
    assign day_norm   = (i_day_in == 5'd0) ? 5'd1 : i_day_in;
    assign month_norm = (i_month_in == 4'd0) ? 4'd1 :
                        (i_month_in > 4'd12) ? 4'd12 : i_month_in;

    always_comb begin
        n_state = r_state;
        n_left  = r_left;
        n_date  = r_date;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_RUN;
                    n_date  = '{day: day_norm, month: month_norm, year: i_year_in};
                    case (gdd_pkg::op_of(i_func))
                        gdd_pkg::OP_DAY: begin
                            // a week is seven day steps
                            n_left = (i_func == gdd_pkg::FN_WEEK) ?
                                     ((cnt_ext << 3) - cnt_ext) : cnt_ext;
                        end
                        gdd_pkg::OP_MONTH: n_left = cnt_ext;
                        gdd_pkg::OP_YEAR:  n_left = gdd_pkg::LEFT_W'(1);
                        default:           n_left = '0;
                    endcase
                end
            end
            S_RUN: begin
                if (r_left != '0) begin
                    n_date = step_date;
                    n_left = r_left - gdd_pkg::LEFT_W'(1);
                end else if (finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_date <= n_date;
        if (accept) begin
            r_count     <= cnt_in;
            r_req.op    <= gdd_pkg::op_of(i_func);
            r_req.scale <= gdd_pkg::scale_of(i_func);
        end
        if (finish) begin
            r_out <= r_date;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_day_out   = r_out.day;
    assign o_month_out = r_out.month;
    assign o_year_out  = r_out.year;

    a_accept_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_RUN))
        else $error("accepted beat did not start the sequencer");

    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (o_valid && (r_state == S_IDLE)))
        else $error("finished item did not reach the output register");

    a_run_normalised: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> ((r_date.day != 5'd0) && (r_date.month >= 4'd1)
                                && (r_date.month <= 4'd12)))
        else $error("working date left the normalised range");

    a_out_normalised: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_day_out != 5'd0) && (o_month_out >= 4'd1) && (o_month_out <= 4'd12)))
        else $error("result date out of range");

endmodule

/* tb/gdd_date_check.sv */
// Date checker for the Gregorian date decrement block: predicts each result from the input beat
// and compares it field by field with what the block returns. Depends on gdd_pkg.
module gdd_date_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [4:0]  i_day_in,
    input  logic [3:0]  i_month_in,
    input  logic [15:0] i_year_in,
    input  logic [2:0]  i_func,
    input  logic [15:0] i_count,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [4:0]  o_day_out,
    input  logic [3:0]  o_month_out,
    input  logic [15:0] o_year_out,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    gdd_pkg::t_date due_dates[$];
    int    errors  = 0;
    int    checked = 0;

    function automatic logic [4:0] month_days(input logic [15:0] y, input logic [3:0] m);
        int sy;
        bit leap;
        sy   = int'($signed(y));
        leap = (sy % 4 == 0 && sy % 100 != 0) || (sy % 400 == 0);
        case (m)
            4'd2:                     return leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  return 5'd30;
            default:                  return 5'd31;
        endcase
    endfunction

    function automatic gdd_pkg::t_date predict_date(
        input logic [4:0] d_in, input logic [3:0] m_in, input logic [15:0] y_in,
        input logic [2:0] unit, input logic [15:0] n_in);
        gdd_pkg::t_date r;
        longint     n;
        longint     steps;
        logic [4:0] len;
        r.day   = (d_in == 5'd0) ? 5'd1 : d_in;
        r.month = (m_in == 4'd0) ? 4'd1 : ((m_in > 4'd12) ? 4'd12 : m_in);
        r.year  = y_in;
        n       = longint'(n_in) & ((longint'(1) << gdd_pkg::COUNT_BITS) - 1);
        case (unit)
            gdd_pkg::FN_DAY, gdd_pkg::FN_WEEK: begin
                steps = (unit == gdd_pkg::FN_WEEK) ? n * 7 : n;
                for (longint i = 0; i < steps; i++) begin
                    if (r.day <= 5'd1) begin
                        // roll back over the month end, or the year end from January
                        if (r.month <= 4'd1) begin
                            r.month = 4'd12;
                            r.day   = 5'd31;
                            r.year  = r.year - 16'd1;
                        end else begin
                            r.month = r.month - 4'd1;
                            r.day   = month_days(r.year, r.month);
                        end
                    end else begin
                        r.day = r.day - 5'd1;
                    end
                end
            end
            gdd_pkg::FN_MONTH: begin
                for (longint i = 0; i < n; i++) begin
                    if (r.month <= 4'd1) begin
                        r.month = 4'd12;
                        r.year  = r.year - 16'd1;
                    end else begin
                        r.month = r.month - 4'd1;
                    end
                    // clamp the day to the new month
                    len = month_days(r.year, r.month);
                    if (r.day > len) r.day = len;
                end
            end
            gdd_pkg::FN_YEAR:       r.year = r.year - 16'(n);
            gdd_pkg::FN_DECADE:     r.year = r.year - 16'(n * 10);
            gdd_pkg::FN_CENTURY:    r.year = r.year - 16'(n * 100);
            gdd_pkg::FN_MILLENNIUM: r.year = r.year - 16'(n * 1000);
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        gdd_pkg::t_date got;
        gdd_pkg::t_date want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got = '{day: o_day_out, month: o_month_out, year: o_year_out};
                if (due_dates.size() == 0) begin
                    report_mismatch("result beat with nothing due, day", got.day, 0);
                end else begin
                    want = due_dates.pop_front();
                    if (got.day !== want.day)
                        report_mismatch("day", got.day, want.day);
                    if (got.month !== want.month)
                        report_mismatch("month", got.month, want.month);
                    if (got.year !== want.year)
                        report_mismatch("year", $signed(got.year), $signed(want.year));
                    checked++;
                end
            end
            if (i_valid && o_ready)
                due_dates.push_back(predict_date(i_day_in, i_month_in, i_year_in,
                                                 i_func, i_count));
        end
        o_fail_count <= errors;
        o_pending    <= due_dates.size();
        o_checked    <= checked;
    end

endmodule

/* tb/gregorian_date_decrement_test.sv */
// Testbench top for the Gregorian date decrement block: drives directed and random date beats,
// idles both channels and gives the verdict. Depends on gdd_pkg, gdd_date_check and the block.
module gregorian_date_decrement_test;

    // Timeout limit for the whole run, with a wide margin.
    localparam int LIMIT     = 2_000_000;
    localparam int HOLD_LEN  = 120;
    localparam int IDLE_PCT  = 21;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic [4:0]  i_day_in   = 5'd1;
    logic [3:0]  i_month_in = 4'd1;
    logic [15:0] i_year_in  = 16'd0;
    logic [2:0]  i_func     = gdd_pkg::FN_DAY;
    logic [15:0] i_count    = 16'd0;
    logic        i_ready    = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [4:0]  o_day_out;
    logic [3:0]  o_month_out;
    logic [15:0] o_year_out;

    logic calm       = 1'b0;
    logic hold_go    = 1'b0;
    logic hold_spent = 1'b0;
    int   hold_left  = 0;
    int   sent       = 0;
    int   cycles     = 0;
    int   fail_count;
    int   pending;
    int   checked;

    gregorian_date_decrement dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_day_in   (i_day_in),
        .i_month_in (i_month_in),
        .i_year_in  (i_year_in),
        .i_func     (i_func),
        .i_count    (i_count),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_day_out  (o_day_out),
        .o_month_out(o_month_out),
        .o_year_out (o_year_out)
    );

    gdd_date_check date_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_day_in    (i_day_in),
        .i_month_in  (i_month_in),
        .i_year_in   (i_year_in),
        .i_func      (i_func),
        .i_count     (i_count),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_day_out   (o_day_out),
        .o_month_out (o_month_out),
        .o_year_out  (o_year_out),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Receiver: one long hold-off when asked, else random back-pressure, none while calm.
    always @(posedge i_clk) begin
        if (hold_go && !hold_spent) begin
            hold_spent <= 1'b1;
            hold_left  <= HOLD_LEN;
            i_ready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (calm) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin
        while (cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timeout after %0d cycles", LIMIT);
        $display("Some tests failed");
        $finish;
    end

    task automatic send_date(input logic [4:0] d, input logic [3:0] m, input logic [15:0] y,
                             input logic [2:0] f, input logic [15:0] n);
        int gap = 0;
        if (!calm)
            while ($urandom_range(99) < IDLE_PCT) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_day_in   <= d;
        i_month_in <= m;
        i_year_in  <= y;
        i_func     <= f;
        i_count    <= n;
        // hold the beat until the block takes it
        do @(posedge i_clk); while (!o_ready);
        sent++;
    endtask

    task automatic send_random();
        logic [2:0]  f;
        logic [15:0] n;
        logic [15:0] y;
        int          pick;
        f    = 3'($urandom_range(7));
        pick = $urandom_range(99);
        case (f)
            gdd_pkg::FN_DAY, gdd_pkg::FN_MONTH:
                n = (pick < 8) ? 16'($urandom_range(3000, 200)) : 16'($urandom_range(40));
            gdd_pkg::FN_WEEK:
                n = (pick < 8) ? 16'($urandom_range(400, 60)) : 16'($urandom_range(12));
            default:
                n = (pick < 30) ? 16'($urandom_range(5)) : 16'($urandom);
        endcase
        pick = $urandom_range(99);
        if (pick < 40)
            y = 16'($urandom);
        else if (pick < 80)
            y = 16'(1600 + $urandom_range(900));
        else
            y = 16'($urandom_range(8)) - 16'd4;
        send_date(5'($urandom_range(31)), 4'($urandom_range(15)), y, f, n);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // month and year roll-over, leap rules
        send_date(5'd1,  4'd1,  16'd2000, gdd_pkg::FN_DAY, 16'd1);
        send_date(5'd1,  4'd3,  16'd2000, gdd_pkg::FN_DAY, 16'd1);
        send_date(5'd1,  4'd3,  16'd1900, gdd_pkg::FN_DAY, 16'd1);
        send_date(5'd1,  4'd3,  16'd2024, gdd_pkg::FN_DAY, 16'd1);
        send_date(5'd1,  4'd3,  -16'sd4,  gdd_pkg::FN_DAY, 16'd1);
        send_date(5'd1,  4'd3,  16'd0,    gdd_pkg::FN_DAY, 16'd1);
        // day zero, month zero, month above twelve
        send_date(5'd0,  4'd5,  16'd2023, gdd_pkg::FN_DAY, 16'd0);
        send_date(5'd15, 4'd0,  16'd2023, gdd_pkg::FN_MONTH, 16'd1);
        send_date(5'd31, 4'd15, 16'd2023, gdd_pkg::FN_DAY, 16'd2);
        // day beyond the month length under each kind of unit
        send_date(5'd31, 4'd2,  16'd2023, gdd_pkg::FN_DAY, 16'd3);
        send_date(5'd31, 4'd3,  16'd2023, gdd_pkg::FN_MONTH, 16'd1);
        send_date(5'd29, 4'd2,  16'd2024, gdd_pkg::FN_YEAR, 16'd1);
        // unused selector and zero count
        send_date(5'd12, 4'd7,  16'd1999, 3'd7, 16'd5);
        send_date(5'd12, 4'd7,  16'd1999, gdd_pkg::FN_MONTH, 16'd0);
        // year wrap, then mid-size counts of decades, weeks and months
        send_date(5'd1,  4'd1,  16'h8000, gdd_pkg::FN_YEAR, 16'd1);
        send_date(5'd1,  4'd1,  16'h8000, gdd_pkg::FN_DAY, 16'd1);
        send_date(5'd31, 4'd15, 16'hFFFF, gdd_pkg::FN_MILLENNIUM, 16'hFFFF);
        send_date(5'd10, 4'd6,  16'h7FFF, gdd_pkg::FN_CENTURY, 16'hFFFF);
        send_date(5'd20, 4'd8,  16'd1987, gdd_pkg::FN_DECADE, 16'd250);
        send_date(5'd30, 4'd4,  16'd2001, gdd_pkg::FN_WEEK, 16'd5);
        send_date(5'd31, 4'd12, 16'd2004, gdd_pkg::FN_MONTH, 16'd14);
        // full count of day steps
        send_date(5'd31, 4'd12, 16'h7FFF, gdd_pkg::FN_DAY, 16'hFFFF);

        repeat (30) send_random();

        // long output stall: keep offering quick beats so the input backs up
        calm    <= 1'b1;
        hold_go <= 1'b1;
        repeat (8)
            send_date(5'($urandom_range(31)), 4'($urandom_range(15)), 16'($urandom),
                      3'($urandom_range(gdd_pkg::FN_MILLENNIUM, gdd_pkg::FN_YEAR)),
                      16'($urandom));
        repeat (30) send_random();
        calm <= 1'b0;
        repeat (10) send_random();

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d date beats over every unit, leap and wrap cases and a long stall;",
                 sent);
        $display("checked %0d results against the predicted dates.", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/gdd_pkg.sv
hdl/gdd_step.sv
hdl/gregorian_date_decrement.sv
tb/gdd_date_check.sv
tb/gregorian_date_decrement_test.sv
